[rtl/b64dec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64dec_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned AccW    = 3 * SextetW;
  localparam int unsigned GroupW  = 4 * SextetW;
  localparam int unsigned CountW  = 2;

  localparam logic [CharW-1:0] CharUpperA = 8'h41;
  localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
  localparam logic [CharW-1:0] CharLowerA = 8'h61;
  localparam logic [CharW-1:0] CharLowerZ = 8'h7A;
  localparam logic [CharW-1:0] CharDigit0 = 8'h30;
  localparam logic [CharW-1:0] CharDigit9 = 8'h39;
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;
  localparam logic [CharW-1:0] CharSlash  = 8'h2F;
  localparam logic [CharW-1:0] CharPad    = 8'h3D;

  // Position of a character inside its group of four
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosThird  = 2'd2;
  localparam logic [1:0] PosFourth = 2'd3;

  // Byte counts of a decoded group
  localparam logic [CountW-1:0] CntNone  = 2'd0;
  localparam logic [CountW-1:0] CntOne   = 2'd1;
  localparam logic [CountW-1:0] CntTwo   = 2'd2;
  localparam logic [CountW-1:0] CntThree = 2'd3;

  typedef struct packed {
    logic               ok;
    logic [SextetW-1:0] val;
  } sextet_t;

  // One decoded group, most significant byte in the top bits
  typedef struct packed {
    logic [GroupW-1:0] bits;
    logic [CountW-1:0] cnt;
    logic              bad;
  } group_t;

  function automatic sextet_t sextet_of(logic [CharW-1:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r.val = SextetW'(c - CharUpperA);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      r.val = SextetW'(c - CharLowerA + 8'd26);
    end else if (c >= CharDigit0 && c <= CharDigit9) begin
      r.val = SextetW'(c - CharDigit0 + 8'd52);
    end else if (c == CharPlus) begin
      r.val = 6'd62;
    end else if (c == CharSlash) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/b64dec_byte_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64dec_byte_buf
// Holds one decoded group and hands its bytes out one per transaction.
// ----------------------------------------------------------------------------
module b64dec_byte_buf
  import b64dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  group_t           group_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [CharW-1:0] byte_o,
  output logic             last_o,
  output logic             bad_o
);

  logic [GroupW-1:0] bits_q, bits_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              bad_q, bad_d;

  always_comb begin
    bits_d = bits_q;
    cnt_d  = cnt_q;
    bad_d  = bad_q;
    priority if (load_i) begin
      bits_d = group_i.bits;
      cnt_d  = group_i.cnt;
      bad_d  = group_i.bad;
    end else if (pop_i) begin
      // advance to the next byte of the group
      bits_d = {bits_q[GroupW-CharW-1:0], CharW'(0)};
      cnt_d  = cnt_q - CntOne;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntNone;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
    bad_q  <= bad_d;
  end

  assign valid_o = (cnt_q != CntNone);
  assign byte_o  = bits_q[GroupW-1 -: CharW];
  assign last_o  = (cnt_q == CntOne);
  assign bad_o   = bad_q;

endmodule

[rtl/base64_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_unit
// Streaming base64 decoder: one text character in, decoded bytes out.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the slave side and collects
// groups of four. The first three characters only update the group state; the
// fourth decodes the group in the same cycle into a byte buffer, which hands
// out three bytes (two if the fourth character is '=', one if the third is
// '='), most significant first, one per output transaction, tlast on the final
// one. A character outside the alphabet counts as zero and sets tuser on every
// byte of its group. A partial group left at the end of the stream yields
// nothing. Throughput is one character per cycle: the single group buffer
// drains before the next group completes, so an unstalled output side never
// holds the input back; when the output stalls, the fourth character of the
// next group waits until that buffer is down to its last byte being taken.
// ----------------------------------------------------------------------------
module base64_decoder_unit
  import b64dec_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave side
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [CharW-1:0] s_axis_tdata,   // [7:0] text_char
  // master side
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [7:0] data_byte
  output logic             m_axis_tlast,   // group_end
  output logic             m_axis_tuser    // [0] bad_char
);

  // Group state
  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      pos_q, pos_d;
  logic            pad3_q, pad3_d;
  logic            err_q, err_d;

  logic               s_hs, m_hs, load;
  sextet_t            sx;
  logic               is_pad, char_bad;
  logic [SextetW-1:0] v;
  group_t             group;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;

  // Accept freely inside a group; the fourth character needs the buffer free
  // or about to be freed by its last byte leaving.
  assign s_axis_tready = (pos_q != PosFourth) || !m_axis_tvalid ||
                         (m_axis_tlast && m_axis_tready);

  assign load = s_hs && (pos_q == PosFourth);

  always_comb begin
    sx       = sextet_of(s_axis_tdata);
    is_pad   = (s_axis_tdata == CharPad);
    // '=' is legal only in third or fourth place
    char_bad = !sx.ok && !(is_pad && pos_q[1]);
    v        = sx.ok ? sx.val : '0;

    group.bits = {acc_q, (pad3_q ? SextetW'(0) : v)};
    group.bad  = err_q || char_bad;
    priority if (pad3_q) begin
      group.cnt = CntOne;
    end else if (is_pad) begin
      group.cnt = CntTwo;
    end else begin
      group.cnt = CntThree;
    end

    acc_d  = acc_q;
    pos_d  = pos_q;
    pad3_d = pad3_q;
    err_d  = err_q;
    if (s_hs) begin
      if (pos_q == PosFourth) begin
        // group done: clear for the next one
        acc_d  = '0;
        pos_d  = PosFirst;
        pad3_d = 1'b0;
        err_d  = 1'b0;
      end else begin
        acc_d  = {acc_q[AccW-SextetW-1:0], v};
        pos_d  = pos_q + 2'd1;
        pad3_d = pad3_q || (is_pad && (pos_q == PosThird));
        err_d  = err_q || char_bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pos_q  <= PosFirst;
      pad3_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pos_q  <= pos_d;
      pad3_q <= pad3_d;
      err_q  <= err_d;
    end
  end

  b64dec_byte_buf u_byte_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .group_i (group),
    .pop_i   (m_hs),
    .valid_o (m_axis_tvalid),
    .byte_o  (m_axis_tdata),
    .last_o  (m_axis_tlast),
    .bad_o   (m_axis_tuser)
  );

  // A group is only loaded when no undelivered byte would be overwritten
  a_load_safe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!m_axis_tvalid || (m_axis_tlast && m_axis_tready)))
    else $error("group loaded over undelivered bytes");

  // A completed group always shows up on the output next cycle
  a_load_visible : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("decoded group missing on output");

  // Taking the last byte with no new group empties the buffer
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_hs && m_axis_tlast && !load) |=> !m_axis_tvalid)
    else $error("output still valid after last byte of group");

  // Each accepted character advances the group position by one
  a_pos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> (pos_q == $past(pos_q) + 2'd1))
    else $error("character position did not advance");

endmodule

[tb/tb_base64_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_decoder_unit
// Self-checking bench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// Characters are pushed on the slave side, one per transaction. A scoreboard
// follows the group state of the decoder and, on every fourth character,
// queues the bytes that group should give. Each byte taken from the master
// side is compared with the oldest queued byte (data, tlast, tuser). A short
// hand-written string covers the alphabet edges, all padding forms and
// characters outside the alphabet; random groups follow, mostly well formed
// with some noise, misplaced pads and broken fragments. Four phases vary the
// sender gaps and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_base64_decoder_unit;
  import b64dec_pkg::*;

  localparam int unsigned StallLimit  = 2000;  // cycles without any transaction
  localparam int unsigned CharsPerRun = 125;   // least random characters per phase
  localparam int unsigned MaxReports  = 10;

  // One decoded byte as seen on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } out_byte_t;

  // Follows the decoder's group state and holds the bytes still to come
  class decode_board;
    logic [AccW-1:0] acc;
    logic [1:0]      pos;
    bit              pad_third;
    bit              grp_bad;
    out_byte_t       owed[$];
    int unsigned     mismatches;

    function new();
      acc        = '0;
      pos        = PosFirst;
      pad_third  = 1'b0;
      grp_bad    = 1'b0;
      mismatches = 0;
    endfunction

    // Alphabet value of c, or -1 when c lies outside it
    static function int alpha_value(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - 65;
      if (c >= "a" && c <= "z") return int'(c) - 97 + 26;
      if (c >= "0" && c <= "9") return int'(c) - 48 + 52;
      if (c == CharPlus)  return 62;
      if (c == CharSlash) return 63;
      return -1;
    endfunction

    function void note_char(logic [7:0] c);
      int                code;
      logic [5:0]        sx;
      bit                is_pad;
      logic [GroupW-1:0] word;
      int                n;
      code   = alpha_value(c);
      is_pad = (c == CharPad);
      sx     = '0;
      if (pos == PosFirst) begin
        acc       = '0;
        pad_third = 1'b0;
        grp_bad   = 1'b0;
      end
      if (code >= 0) begin
        sx = code[5:0];
      end else if (is_pad && pos >= PosThird) begin
        if (pos == PosThird) pad_third = 1'b1;
      end else begin
        grp_bad = 1'b1;
      end
      if (pos != PosFourth) begin
        acc = {acc[AccW-SextetW-1:0], sx};
        pos = pos + 2'd1;
        return;
      end
      // fourth character: a pad in third place decides on its own
      if (pad_third) begin
        n  = 1;
        sx = '0;
      end else if (is_pad) begin
        n = 2;
      end else begin
        n = 3;
      end
      word = {acc, sx};
      for (int k = 0; k < n; k++) begin
        owed.push_back('{data: word[GroupW-1-8*k -: 8], last: (k == n - 1),
                         bad: grp_bad});
      end
      pos = PosFirst;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic bad);
      out_byte_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected byte %02h last=%0b bad=%0b", $realtime, data, last, bad);
        return;
      end
      want = owed.pop_front();
      if (want.data !== data || want.last !== last || want.bad !== bad) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: byte mismatch: expected %02h last=%0b bad=%0b, got %02h last=%0b bad=%0b",
                   $realtime, want.data, want.last, want.bad, data, last, bad);
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [CharW-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  decode_board board    = new();
  int unsigned send_idle_pct;   // chance in a hundred of a sender gap
  int unsigned recv_stall_pct;  // chance in a hundred of a receiver stall
  int unsigned quiet_cycles;
  int unsigned sent;

  base64_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: check the byte taken at this edge, then pick the next tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: count edges with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL base64_decoder_unit");
      $finish;
    end
  end

  // Offer one character, holding it until the transaction completes
  task automatic push_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_char(c);
    sent++;
  endtask

  task automatic push_text(string t);
    for (int i = 0; i < t.len(); i++) push_char(t[i]);
  endtask

  function automatic logic [7:0] any_alpha();
    int unsigned idx;
    idx = $urandom_range(63);
    if (idx < 26) return 8'(65 + idx);
    if (idx < 52) return 8'(97 + idx - 26);
    if (idx < 62) return 8'(48 + idx - 52);
    return (idx == 62) ? CharPlus : CharSlash;
  endfunction

  // One random group: mostly well formed, some noise, some broken
  task automatic push_random_group();
    logic [7:0]  g[4];
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99);
    len  = 4;
    foreach (g[i]) g[i] = any_alpha();
    if (kind < 45) begin
      // plain group of four
    end else if (kind < 58) begin
      g[3] = CharPad;
    end else if (kind < 68) begin
      g[2] = CharPad;
      g[3] = CharPad;
    end else if (kind < 73) begin
      // pad in third place, fourth ignored unless outside the alphabet
      g[2] = CharPad;
      if ($urandom_range(1)) g[3] = 8'($urandom_range(255));
    end else if (kind < 87) begin
      g[$urandom_range(3)] = 8'($urandom_range(255));
    end else if (kind < 94) begin
      g[$urandom_range(1)] = CharPad;
    end else begin
      // fragment that shifts the group boundary
      len = $urandom_range(1, 3);
      foreach (g[i]) if ($urandom_range(1)) g[i] = 8'($urandom_range(255));
    end
    for (int i = 0; i < len; i++) push_char(g[i]);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target         = sent + CharsPerRun;
    while (sent < target) push_random_group();
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent           = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Alphabet edges and every padding form
    push_text("+/9zTWE=TQ==TQ=A");
    // pad in third place with a bad fourth character still flags the group
    push_text("TQ=");
    push_char(8'h7F);
    // pad first plus both byte extremes: all three bytes flagged
    push_char(CharPad);
    push_char("A");
    push_char(8'hFF);
    push_char(8'h00);
    // pad in second place counts as a bad character
    push_text("A=B=");

    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(33, 33);

    // drop tvalid at the edge of the final transaction
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    // let any stray byte show up before judging
    repeat (10) @(posedge clk_i);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS base64_decoder_unit");
    end else begin
      $display("FAIL base64_decoder_unit");
    end
    $finish;
  end

endmodule

[files.f]
rtl/b64dec_pkg.sv
rtl/b64dec_byte_buf.sv
rtl/base64_decoder_unit.sv
tb/tb_base64_decoder_unit.sv
